@@ rtl/core/char_lcd_nibble_interface_unit_defines.svh @@
// assertion macros for the character lcd nibble interface
`ifndef CHAR_LCD_NIBBLE_INTERFACE_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CLNI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define CLNI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define CLNI_ASSERT_SAME(label, ante, cons)
`define CLNI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/clni_pkg.sv @@
package clni_pkg;

  localparam int unsigned StepW = 4;
  localparam int unsigned PhaseW = 2;

  // request kinds
  localparam logic [2:0] MODE_CMD    = 3'd0;
  localparam logic [2:0] MODE_CHAR   = 3'd1;
  localparam logic [2:0] MODE_CURSOR = 3'd2;
  localparam logic [2:0] MODE_INIT   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // register indexes on the write port
  localparam logic REG_ROW2_OFFSET = 1'b0;
  localparam logic REG_ROW3_OFFSET = 1'b1;

  // microprogram entry points
  localparam logic [StepW-1:0] STEP_CMD    = 4'd0;
  localparam logic [StepW-1:0] STEP_CHAR   = 4'd1;
  localparam logic [StepW-1:0] STEP_CURSOR = 4'd2;
  localparam logic [StepW-1:0] STEP_INIT   = 4'd3;
  localparam logic [StepW-1:0] STEP_CLEAR  = 4'd10;

  localparam logic [PhaseW-1:0] PHASE_LAST = 2'd3;

  localparam logic [6:0] ROW0_BASE = 7'h00;
  localparam logic [6:0] ROW1_BASE = 7'h40;
  localparam logic [7:0] SET_DDRAM = 8'h80;

  // one control word: one byte on the bus
  typedef struct packed {
    logic       use_data;   // send the request word instead of the constant
    logic       rs;
    logic       done;       // end of program, return to idle
    logic [7:0] const_byte;
  } uword_t;

  typedef struct packed {
    logic              busy;
    logic [StepW-1:0]  step;
    logic [PhaseW-1:0] phase;
  } seq_stat_t;

endpackage

@@ rtl/core/clni_urom.sv @@
module clni_urom (
  input  logic [clni_pkg::StepW-1:0] step_i,
  output clni_pkg::uword_t           uword_o
);
  import clni_pkg::*;

  always_comb begin
    unique case (step_i)
      4'd0:    uword_o = '{use_data: 1'b1, rs: 1'b0, done: 1'b1, const_byte: 8'h00};
      4'd1:    uword_o = '{use_data: 1'b1, rs: 1'b1, done: 1'b1, const_byte: 8'h00};
      4'd2:    uword_o = '{use_data: 1'b1, rs: 1'b0, done: 1'b1, const_byte: 8'h00};
      4'd3:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h33};
      4'd4:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h32};
      4'd5:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h28};
      4'd6:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h0c};
      4'd7:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h06};
      4'd8:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h01};
      4'd9:    uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b1, const_byte: 8'h80};
      4'd10:   uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b0, const_byte: 8'h01};
      4'd11:   uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b1, const_byte: 8'h80};
      default: uword_o = '{use_data: 1'b0, rs: 1'b0, done: 1'b1, const_byte: 8'h00};
    endcase
  end

endmodule

@@ rtl/core/clni_seq.sv @@
module clni_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  logic [2:0]           mode_i,
  input  logic                 out_accept_i,
  input  clni_pkg::uword_t     uword_i,
  output clni_pkg::seq_stat_t  stat_o
);
  import clni_pkg::*;

  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [StepW-1:0]  entry;
  logic              entry_ok;

  always_comb begin
    entry_ok = 1'b1;
    unique case (mode_i)
      MODE_CMD:    entry = STEP_CMD;
      MODE_CHAR:   entry = STEP_CHAR;
      MODE_CURSOR: entry = STEP_CURSOR;
      MODE_INIT:   entry = STEP_INIT;
      MODE_CLEAR:  entry = STEP_CLEAR;
      default: begin
        entry    = STEP_CMD;
        entry_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    phase_d = phase_q;
    if (in_accept_i && entry_ok) begin
      busy_d  = 1'b1;
      step_d  = entry;
      phase_d = '0;
    end else if (busy_q && out_accept_i) begin
      phase_d = phase_q + 2'd1;
      if (phase_q == PHASE_LAST) begin
        if (uword_i.done) begin
          busy_d = 1'b0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      phase_q <= '0;
    end else begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      phase_q <= phase_d;
    end
  end

  assign stat_o = '{busy: busy_q, step: step_q, phase: phase_q};

endmodule

@@ rtl/core/clni_dp.sv @@
module clni_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  logic [2:0]          mode_i,
  input  logic [7:0]          byte_value_i,
  input  logic [1:0]          row_i,
  input  logic [5:0]          col_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  input  clni_pkg::uword_t    uword_i,
  input  clni_pkg::seq_stat_t stat_i,
  output logic [3:0]          nibble_o,
  output logic                rs_pin_o,
  output logic                en_pin_o,
  output logic                last_o,
  output logic                ready_res_o,
  output logic [7:0]          char_total_o
);
  import clni_pkg::*;

  logic [6:0] row2_q, row3_q;
  logic       init_q;
  logic [7:0] count_q;
  logic [7:0] data_q, data_d;
  logic [6:0] base;
  logic [6:0] addr;
  logic [7:0] bus_byte;

  always_comb begin
    unique case (row_i)
      2'd0: base = ROW0_BASE;
      2'd1: base = ROW1_BASE;
      2'd2: base = row2_q;
      2'd3: base = row3_q;
    endcase
  end

  // address wraps at 7 bits
  assign addr   = base + {1'b0, col_i};
  assign data_d = (mode_i == MODE_CURSOR) ? (SET_DDRAM | {1'b0, addr}) : byte_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row2_q  <= 7'd16;
      row3_q  <= 7'd80;
      init_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ROW3_OFFSET) row3_q <= cfg_data_i;
        else                                row2_q <= cfg_data_i;
      end
      if (in_accept_i && mode_i == MODE_CHAR) count_q <= count_q + 8'd1;
      if (in_accept_i && mode_i == MODE_INIT) init_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) data_q <= data_d;
  end

  assign bus_byte     = uword_i.use_data ? data_q : uword_i.const_byte;
  assign nibble_o     = stat_i.phase[1] ? bus_byte[3:0] : bus_byte[7:4];
  assign en_pin_o     = ~stat_i.phase[0];
  assign rs_pin_o     = uword_i.rs;
  assign last_o       = uword_i.done && (stat_i.phase == PHASE_LAST);
  assign ready_res_o  = init_q;
  assign char_total_o = count_q;

endmodule

@@ rtl/core/char_lcd_nibble_interface_unit.sv @@
// latency: first pin word is offered the cycle after a request is accepted
// throughput: one pin word per cycle while out_ready_i is high, 4 words per byte; a request
//   sends one byte (command, character, cursor), two (clear and home) or seven (initialize),
//   stepped by the single step counter; the next request is taken after its last word is accepted
// reset: async active low; idle, init flag and character count cleared, row bases 16 and 80
module char_lcd_nibble_interface_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] byte_value_i,
  input  logic [1:0] row_i,
  input  logic [5:0] col_i,
  // register write port: index 0 row2_offset, 1 row3_offset
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i,
  // pin word channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] nibble_o,
  output logic       rs_pin_o,
  output logic       en_pin_o,
  output logic       last_o,
  output logic       ready_res_o,
  output logic [7:0] char_total_o
);
  import clni_pkg::*;
  `include "char_lcd_nibble_interface_unit_defines.svh"

  seq_stat_t stat;
  uword_t    uword;
  logic      in_accept;
  logic      out_accept;

  // one request in flight; unknown modes are taken and dropped
  assign in_ready_o  = ~stat.busy;
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_valid_o = stat.busy;
  assign out_accept  = out_valid_o & out_ready_i;

  // step counter, byte phase and end-of-program jump
  clni_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .mode_i       (mode_i),
    .out_accept_i (out_accept),
    .uword_i      (uword),
    .stat_o       (stat)
  );

  // microprogram: one control word per byte sent
  clni_urom u_urom (
    .step_i  (stat.step),
    .uword_o (uword)
  );

  // request word, cursor address, counters and pin word forming
  clni_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .mode_i       (mode_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .uword_i      (uword),
    .stat_i       (stat),
    .nibble_o     (nibble_o),
    .rs_pin_o     (rs_pin_o),
    .en_pin_o     (en_pin_o),
    .last_o       (last_o),
    .ready_res_o  (ready_res_o),
    .char_total_o (char_total_o)
  );

  // no request taken while pin words are pending
  `CLNI_ASSERT_SAME(a_one_in_flight, out_valid_o, !in_ready_o)
  // the last word ends the request
  `CLNI_ASSERT_NEXT(a_last_ends, out_accept && last_o, !out_valid_o)
  // an enable-high word is always followed by its enable-low partner
  `CLNI_ASSERT_NEXT(a_en_pairs, out_accept && en_pin_o, out_valid_o && !en_pin_o)
  // initialize sets the ready flag before its first pin word
  `CLNI_ASSERT_NEXT(a_init_ready, in_accept && mode_i == MODE_INIT, ready_res_o)

endmodule
